[hdl/mer_pkg.sv]
// Shared constants, control-word layout and microprogram for the ellipse rasterizer.
package mer_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int SCREEN_BITS    = 13;
  localparam logic [SCREEN_BITS-1:0] SCREEN_RESET = 13'd800;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam int PC_BITS = 5;

  // Jump conditions
  localparam logic [2:0] JC_NONE     = 3'd0;
  localparam logic [2:0] JC_ALWAYS   = 3'd1;
  localparam logic [2:0] JC_IDLE     = 3'd2;
  localparam logic [2:0] JC_ENTER_R2 = 3'd3;
  localparam logic [2:0] JC_R2       = 3'd4;
  localparam logic [2:0] JC_DEC_NEG  = 3'd5;
  localparam logic [2:0] JC_DEC_POS  = 3'd6;

  // Multiplier A operand
  localparam logic [2:0] MA_A   = 3'd0;
  localparam logic [2:0] MA_B   = 3'd1;
  localparam logic [2:0] MA_HSQ = 3'd2;
  localparam logic [2:0] MA_VSQ = 3'd3;
  localparam logic [2:0] MA_P   = 3'd4;

  // Multiplier B operand
  localparam logic [1:0] MB_A  = 2'd0;
  localparam logic [1:0] MB_B  = 2'd1;
  localparam logic [1:0] MB_TX = 2'd2;
  localparam logic [1:0] MB_Y1 = 2'd3;

  // Decision adder operand
  localparam logic [2:0] DO_P    = 3'd0;
  localparam logic [2:0] DO_SNUM = 3'd1;
  localparam logic [2:0] DO_SDEN = 3'd2;
  localparam logic [2:0] DO_VSQ  = 3'd3;
  localparam logic [2:0] DO_HSQ  = 3'd4;

  // Microprogram addresses
  localparam logic [PC_BITS-1:0] U_ST_AA   = 5'd0;
  localparam logic [PC_BITS-1:0] U_ST_BB   = 5'd1;
  localparam logic [PC_BITS-1:0] U_ST_AAB  = 5'd2;
  localparam logic [PC_BITS-1:0] U_ST_SDEN = 5'd3;
  localparam logic [PC_BITS-1:0] U_ST_HSQ  = 5'd4;
  localparam logic [PC_BITS-1:0] U_ST_VSQ  = 5'd5;
  localparam logic [PC_BITS-1:0] U_STEP    = 5'd6;
  localparam logic [PC_BITS-1:0] U_CHK_R2  = 5'd7;
  localparam logic [PC_BITS-1:0] U_EMIT    = 5'd8;
  localparam logic [PC_BITS-1:0] U_R1      = 5'd9;
  localparam logic [PC_BITS-1:0] U_R1SE_0  = 5'd10;
  localparam logic [PC_BITS-1:0] U_R1SE_1  = 5'd11;
  localparam logic [PC_BITS-1:0] U_R1SE_2  = 5'd12;
  localparam logic [PC_BITS-1:0] U_R1E_0   = 5'd13;
  localparam logic [PC_BITS-1:0] U_R1E_1   = 5'd14;
  localparam logic [PC_BITS-1:0] U_R2      = 5'd15;
  localparam logic [PC_BITS-1:0] U_R2SE_0  = 5'd16;
  localparam logic [PC_BITS-1:0] U_R2SE_1  = 5'd17;
  localparam logic [PC_BITS-1:0] U_R2SE_2  = 5'd18;
  localparam logic [PC_BITS-1:0] U_R2S_0   = 5'd19;
  localparam logic [PC_BITS-1:0] U_R2S_1   = 5'd20;
  localparam logic [PC_BITS-1:0] U_TR_0    = 5'd21;
  localparam logic [PC_BITS-1:0] U_TR_1    = 5'd22;
  localparam logic [PC_BITS-1:0] U_TR_2    = 5'd23;
  localparam logic [PC_BITS-1:0] U_TR_3    = 5'd24;
  localparam logic [PC_BITS-1:0] U_TR_4    = 5'd25;
  localparam logic [PC_BITS-1:0] U_TR_5    = 5'd26;
  localparam logic [PC_BITS-1:0] U_TR_6    = 5'd27;
  localparam logic [PC_BITS-1:0] U_NOP     = 5'd28;

  typedef struct packed {
    logic [2:0]         jc;
    logic [PC_BITS-1:0] target;
    logic               done;
    logic               emit;
    logic               mul_en;
    logic [2:0]         mul_a;
    logic [1:0]         mul_b;
    logic               hsq_ld;
    logic               vsq_ld;
    logic               sden_ld;
    logic               dec_en;
    logic               dec_clr;
    logic [2:0]         dec_opnd;
    logic               dec_sub;
    logic               dec_x4;
    logic               step_x;
    logic               step_y;
    logic               set_r2;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   load;
  } ctrl_t;

  typedef struct packed {
    logic active;
    logic in_r2;
    logic enter_r2;
    logic dec_neg;
    logic dec_pos;
    logic out_blocked;
  } flags_t;

  function automatic ucode_t ucode_word(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    w = '0;
    case (pc)
      // start: a^2, b^2, 2a^2 b and the region-1 term
      U_ST_AA: begin
        w.mul_en = 1'b1; w.mul_a = MA_A; w.mul_b = MB_A;
      end
      U_ST_BB: begin
        w.hsq_ld = 1'b1;
        w.mul_en = 1'b1; w.mul_a = MA_B; w.mul_b = MB_B;
      end
      U_ST_AAB: begin
        w.vsq_ld = 1'b1;
        w.mul_en = 1'b1; w.mul_a = MA_HSQ; w.mul_b = MB_B;
      end
      U_ST_SDEN: begin
        w.sden_ld = 1'b1;
        w.dec_en = 1'b1; w.dec_clr = 1'b1; w.dec_opnd = DO_P;
        w.dec_sub = 1'b1; w.dec_x4 = 1'b1;
      end
      U_ST_HSQ: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_HSQ;
      end
      U_ST_VSQ: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_VSQ; w.dec_x4 = 1'b1; w.done = 1'b1;
      end
      // step
      U_STEP: begin
        w.jc = JC_IDLE; w.target = U_NOP;
      end
      U_CHK_R2: begin
        w.jc = JC_ENTER_R2; w.target = U_TR_0;
      end
      U_EMIT: begin
        w.emit = 1'b1; w.jc = JC_R2; w.target = U_R2;
      end
      U_R1: begin
        w.jc = JC_DEC_NEG; w.target = U_R1E_0;
      end
      U_R1SE_0: begin
        w.step_x = 1'b1; w.step_y = 1'b1;
        w.dec_en = 1'b1; w.dec_opnd = DO_VSQ; w.dec_x4 = 1'b1;
      end
      U_R1SE_1: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_SNUM; w.dec_x4 = 1'b1;
      end
      U_R1SE_2: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_SDEN; w.dec_sub = 1'b1; w.dec_x4 = 1'b1;
        w.done = 1'b1;
      end
      U_R1E_0: begin
        w.step_x = 1'b1;
        w.dec_en = 1'b1; w.dec_opnd = DO_VSQ; w.dec_x4 = 1'b1;
      end
      U_R1E_1: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_SNUM; w.dec_x4 = 1'b1; w.done = 1'b1;
      end
      U_R2: begin
        w.jc = JC_DEC_POS; w.target = U_R2S_0;
      end
      U_R2SE_0: begin
        w.step_x = 1'b1; w.step_y = 1'b1;
        w.dec_en = 1'b1; w.dec_opnd = DO_HSQ; w.dec_x4 = 1'b1;
      end
      U_R2SE_1: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_SNUM; w.dec_x4 = 1'b1;
      end
      U_R2SE_2: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_SDEN; w.dec_sub = 1'b1; w.dec_x4 = 1'b1;
        w.done = 1'b1;
      end
      U_R2S_0: begin
        w.step_y = 1'b1;
        w.dec_en = 1'b1; w.dec_opnd = DO_HSQ; w.dec_x4 = 1'b1;
      end
      U_R2S_1: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_SDEN; w.dec_sub = 1'b1; w.dec_x4 = 1'b1;
        w.done = 1'b1;
      end
      // region-2 entry: b^2 tx^2 + 4 a^2 (y-1)^2 - 4 a^2 b^2
      U_TR_0: begin
        w.set_r2 = 1'b1;
        w.mul_en = 1'b1; w.mul_a = MA_VSQ; w.mul_b = MB_TX;
      end
      U_TR_1: begin
        w.mul_en = 1'b1; w.mul_a = MA_P; w.mul_b = MB_TX;
      end
      U_TR_2: begin
        w.dec_en = 1'b1; w.dec_clr = 1'b1; w.dec_opnd = DO_P;
        w.mul_en = 1'b1; w.mul_a = MA_HSQ; w.mul_b = MB_Y1;
      end
      U_TR_3: begin
        w.mul_en = 1'b1; w.mul_a = MA_P; w.mul_b = MB_Y1;
      end
      U_TR_4: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_P; w.dec_x4 = 1'b1;
        w.mul_en = 1'b1; w.mul_a = MA_HSQ; w.mul_b = MB_B;
      end
      U_TR_5: begin
        w.mul_en = 1'b1; w.mul_a = MA_P; w.mul_b = MB_B;
      end
      U_TR_6: begin
        w.dec_en = 1'b1; w.dec_opnd = DO_P; w.dec_sub = 1'b1; w.dec_x4 = 1'b1;
        w.jc = JC_ALWAYS; w.target = U_EMIT;
      end
      U_NOP: begin
        w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/mer_cmd_if.sv]
// Command channel: start or step items with center and radii.
interface mer_cmd_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] center_col;
  logic [COORD_BITS-1:0] center_row;
  logic [COORD_BITS-2:0] radius_horiz;
  logic [COORD_BITS-2:0] radius_vert;

  modport source (
    output valid, command, center_col, center_row, radius_horiz, radius_vert,
    input  ready
  );
  modport sink (
    input  valid, command, center_col, center_row, radius_horiz, radius_vert,
    output ready
  );
endinterface

[hdl/mer_pix_if.sv]
// Pixel channel: one mirrored pixel pair per item.
interface mer_pix_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic        [COORD_BITS:0]   pixel_col;
  logic signed [COORD_BITS+1:0] upper_row;
  logic signed [COORD_BITS+1:0] lower_row;
  logic                         upper_visible;
  logic                         lower_visible;
  logic                         last_point;

  modport source (
    output valid, pixel_col, upper_row, lower_row, upper_visible, lower_visible, last_point,
    input  ready
  );
  modport sink (
    input  valid, pixel_col, upper_row, lower_row, upper_visible, lower_visible, last_point,
    output ready
  );
endinterface

[hdl/mer_sequencer.sv]
// Microprogram sequencer: step counter, control ROM and conditional jumps.
module mer_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            command,
  input  mer_pkg::flags_t flags,
  output mer_pkg::ctrl_t  ctrl
);
  import mer_pkg::*;

  logic               busy;
  logic               busy_next;
  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  ucode_t             word;
  logic               accept;
  logic               blocked;
  logic               run;
  logic               take;

  assign word     = ucode_word(pc);
  assign in_ready = !busy && !rst;
  assign accept   = in_valid && in_ready;
  // hold on the emit step while the output register is still full
  assign blocked  = word.emit && flags.out_blocked;
  assign run      = busy && !blocked;

  always_comb begin
    unique case (word.jc)
      JC_NONE:     take = 1'b0;
      JC_ALWAYS:   take = 1'b1;
      JC_IDLE:     take = !flags.active;
      JC_ENTER_R2: take = flags.enter_r2;
      JC_R2:       take = flags.in_r2;
      JC_DEC_NEG:  take = flags.dec_neg;
      JC_DEC_POS:  take = flags.dec_pos;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.uc   = run ? word : '0;
    ctrl.load = accept && (command == CMD_START);
  end

  always_comb begin
    busy_next = busy;
    pc_next   = pc;
    if (accept) begin
      busy_next = 1'b1;
      pc_next   = (command == CMD_START) ? U_ST_AA : U_STEP;
    end else if (run) begin
      if (word.done) begin
        busy_next = 1'b0;
      end else if (take) begin
        pc_next = word.target;
      end else begin
        pc_next = pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= U_ST_AA;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

endmodule

[hdl/mer_datapath.sv]
// Datapath: walk registers, shared multiplier, decision adder, output register.
module mer_datapath #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mer_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mer_pkg::SCREEN_BITS-1:0]     cfg_data,
  input  logic [COORD_BITS-1:0]               center_col,
  input  logic [COORD_BITS-1:0]               center_row,
  input  logic [COORD_BITS-2:0]               radius_horiz,
  input  logic [COORD_BITS-2:0]               radius_vert,
  input  mer_pkg::ctrl_t                      ctrl,
  output mer_pkg::flags_t                     flags,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COORD_BITS:0]                 pixel_col,
  output logic signed [COORD_BITS+1:0]        upper_row,
  output logic signed [COORD_BITS+1:0]        lower_row,
  output logic                                upper_visible,
  output logic                                lower_visible,
  output logic                                last_point
);
  import mer_pkg::*;

  localparam int RW   = COORD_BITS - 1;
  localparam int XW   = COORD_BITS;
  localparam int YW   = COORD_BITS + 1;
  localparam int SQW  = 2 * COORD_BITS - 2;
  localparam int SW   = 3 * COORD_BITS;
  localparam int MAW  = 3 * COORD_BITS;
  localparam int MBW  = COORD_BITS + 2;
  localparam int PW   = MAW + MBW;
  localparam int DW   = 4 * COORD_BITS;
  localparam int COLW = COORD_BITS + 1;
  localparam int ROWW = COORD_BITS + 2;
  localparam int CMPW = ((ROWW > SCREEN_BITS) ? ROWW : SCREEN_BITS) + 1;

  logic [SCREEN_BITS-1:0] screen_width;
  logic [SCREEN_BITS-1:0] screen_height;

  logic [COORD_BITS-1:0]  saved_col;
  logic [COORD_BITS-1:0]  saved_row;
  logic [RW-1:0]          rad_a;
  logic [RW-1:0]          rad_b;
  logic [XW-1:0]          cur_x;
  logic signed [YW-1:0]   cur_y;
  logic [SQW-1:0]         hsq;
  logic [SQW-1:0]         vsq;
  logic signed [SW-1:0]   snum;
  logic signed [SW-1:0]   sden;
  logic signed [DW-1:0]   dec;
  logic signed [PW-1:0]   prod;
  logic                   in_r2;
  logic                   active;

  logic signed [YW-1:0]   y1;
  logic signed [MAW-1:0]  mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [PW-1:0]   mul_out;
  logic signed [DW-1:0]   opnd;
  logic signed [DW-1:0]   opnd_sh;
  logic signed [DW-1:0]   dec_base;
  logic signed [DW-1:0]   dec_next;

  logic [COLW-1:0]        col_w;
  logic signed [ROWW-1:0] up_w;
  logic signed [ROWW-1:0] lo_w;

  function automatic logic on_screen(input logic [COLW-1:0] c,
                                     input logic signed [ROWW-1:0] r,
                                     input logic [SCREEN_BITS-1:0] w,
                                     input logic [SCREEN_BITS-1:0] h);
    logic col_ok;
    logic row_ok;
    col_ok = CMPW'(c) < CMPW'(w);
    row_ok = !r[ROWW-1] && (CMPW'($unsigned(r)) < CMPW'(h));
    return col_ok && row_ok;
  endfunction

  assign y1 = cur_y - YW'(1);

  always_comb begin
    case (ctrl.uc.mul_a)
      MA_A:    mul_a = $signed(MAW'(rad_a));
      MA_B:    mul_a = $signed(MAW'(rad_b));
      MA_HSQ:  mul_a = $signed(MAW'(hsq));
      MA_VSQ:  mul_a = $signed(MAW'(vsq));
      MA_P:    mul_a = $signed(prod[MAW-1:0]);
      default: mul_a = '0;
    endcase
    case (ctrl.uc.mul_b)
      MB_A:    mul_b = $signed(MBW'(rad_a));
      MB_B:    mul_b = $signed(MBW'(rad_b));
      MB_TX:   mul_b = $signed({1'b0, cur_x, 1'b1});
      MB_Y1:   mul_b = MBW'(y1);
      default: mul_b = '0;
    endcase
  end

  assign mul_out = mul_a * mul_b;

  always_comb begin
    case (ctrl.uc.dec_opnd)
      DO_P:    opnd = $signed(prod[DW-1:0]);
      DO_SNUM: opnd = DW'(snum);
      DO_SDEN: opnd = DW'(sden);
      DO_VSQ:  opnd = $signed(DW'(vsq));
      DO_HSQ:  opnd = $signed(DW'(hsq));
      default: opnd = '0;
    endcase
    opnd_sh  = ctrl.uc.dec_x4 ? (opnd <<< 2) : opnd;
    dec_base = ctrl.uc.dec_clr ? '0 : dec;
    dec_next = ctrl.uc.dec_sub ? (dec_base - opnd_sh) : (dec_base + opnd_sh);
  end

  always_comb begin
    flags.active      = active;
    flags.in_r2       = in_r2;
    flags.enter_r2    = !in_r2 && !(snum < sden);
    flags.dec_neg     = dec[DW-1];
    flags.dec_pos     = !dec[DW-1] && (|dec);
    flags.out_blocked = out_valid && !out_ready;
  end

  assign col_w = COLW'(saved_col) + COLW'(cur_x);
  assign up_w  = ROWW'(saved_row) + ROWW'(cur_y);
  assign lo_w  = ROWW'(saved_row) - ROWW'(cur_y);

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_RESET;
      screen_height <= SCREEN_RESET;
      active        <= 1'b0;
      in_r2         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_SCREEN_WIDTH) begin
          screen_width <= cfg_data;
        end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
          screen_height <= cfg_data;
        end
      end
      if (ctrl.load) begin
        active <= 1'b1;
        in_r2  <= 1'b0;
      end else begin
        if (ctrl.uc.set_r2) begin
          in_r2 <= 1'b1;
        end
        // drop out once y steps below zero
        if (ctrl.uc.step_y && (cur_y == '0)) begin
          active <= 1'b0;
        end
      end
      if (ctrl.uc.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      saved_col <= center_col;
      saved_row <= center_row;
      rad_a     <= radius_horiz;
      rad_b     <= radius_vert;
      cur_x     <= '0;
      cur_y     <= $signed(YW'(radius_vert));
      snum      <= '0;
    end else begin
      if (ctrl.uc.step_x) begin
        cur_x <= cur_x + 1'b1;
        snum  <= snum + $signed(SW'({vsq, 1'b0}));
      end
      if (ctrl.uc.step_y) begin
        cur_y <= cur_y - YW'(1);
        sden  <= sden - $signed(SW'({hsq, 1'b0}));
      end
    end
    if (ctrl.uc.mul_en) begin
      prod <= mul_out;
    end
    if (ctrl.uc.hsq_ld) begin
      hsq <= prod[SQW-1:0];
    end
    if (ctrl.uc.vsq_ld) begin
      vsq <= prod[SQW-1:0];
    end
    if (ctrl.uc.sden_ld) begin
      sden <= $signed({prod[SW-2:0], 1'b0});
    end
    if (ctrl.uc.dec_en) begin
      dec <= dec_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.uc.emit) begin
      pixel_col     <= col_w;
      upper_row     <= up_w;
      lower_row     <= lo_w;
      upper_visible <= on_screen(col_w, up_w, screen_width, screen_height);
      lower_visible <= on_screen(col_w, lo_w, screen_width, screen_height);
      last_point    <= (cur_y == '0);
    end
  end

endmodule

[hdl/midpoint_ellipse_rasterizer_unit.sv]
// Top level of the midpoint ellipse rasterizer.
//
// Usage: send items on cmd. A start item (command 0) loads center and radii
// and produces nothing; each step item (command 1) produces one pixel pair on
// pix: the next point of the right half of the ellipse, as one column and an
// upper and lower row mirrored about the center row, each with an on-screen
// flag. last_point marks the point with y offset zero; steps after it produce
// nothing until the next start. A start during a walk drops the old ellipse.
// Screen size is set through the cfg_write/cfg_index/cfg_data port while idle:
// a rule for the user, which the block itself does not enforce. Items run one
// at a time on a 29-word microprogram over one shared multiplier and one
// decision adder. A start runs to its end before the next ready. A step when
// idle only checks the state and ends; the step that enters region 2 first
// computes the region-2 term (six multiplies), then registers its pixel pair.
// Reset: idle, screen 800 by 800, no ellipse loaded.
// Stall: the result waits in an output register; the next item is still
// accepted and the sequencer only holds on its emit step while that register
// is full.
module midpoint_ellipse_rasterizer_unit #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mer_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mer_pkg::SCREEN_BITS-1:0]    cfg_data,
  mer_cmd_if.sink                            cmd,
  mer_pix_if.source                          pix
);
  import mer_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  mer_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .command  (cmd.command),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  mer_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .center_col    (cmd.center_col),
    .center_row    (cmd.center_row),
    .radius_horiz  (cmd.radius_horiz),
    .radius_vert   (cmd.radius_vert),
    .ctrl          (ctrl),
    .flags         (flags),
    .out_valid     (pix.valid),
    .out_ready     (pix.ready),
    .pixel_col     (pix.pixel_col),
    .upper_row     (pix.upper_row),
    .lower_row     (pix.lower_row),
    .upper_visible (pix.upper_visible),
    .lower_visible (pix.lower_visible),
    .last_point    (pix.last_point)
  );

endmodule

[hdl/mer_checker.sv]
// Port-level checks for the ellipse rasterizer, bound to the top level.
module mer_checker #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic        [COORD_BITS:0]   pixel_col,
  input logic signed [COORD_BITS+1:0] upper_row,
  input logic signed [COORD_BITS+1:0] lower_row,
  input logic                         upper_visible,
  input logic                         lower_visible,
  input logic                         last_point
);

  // a stalled pixel pair holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pixel_col) && $stable(upper_row)
      && $stable(lower_row) && $stable(upper_visible) && $stable(lower_visible)
      && $stable(last_point)))
    else $error("pixel item changed while stalled");

  // the sequencer is busy in the cycle after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after accept");

  // y offset is never negative on an emitted point
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (upper_row >= lower_row))
    else $error("upper row below lower row");

  // the last point is exactly the one where both rows meet
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_point == (upper_row == lower_row)))
    else $error("last_point does not match zero y offset");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker #(
  .COORD_BITS (COORD_BITS)
) u_mer_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (cmd.valid),
  .in_ready      (cmd.ready),
  .out_valid     (pix.valid),
  .out_ready     (pix.ready),
  .pixel_col     (pix.pixel_col),
  .upper_row     (pix.upper_row),
  .lower_row     (pix.lower_row),
  .upper_visible (pix.upper_visible),
  .lower_visible (pix.lower_visible),
  .last_point    (pix.last_point)
);
